@@ src/bohacc_pkg.sv @@
package bohacc_pkg;

	// particle slots and harmonic layout (degree four, m = -4..4)
	localparam int PW        = 13;
	localparam int SLOTS     = 8192;
	localparam int HDEG      = 4;
	localparam int HARMONICS = 2 * HDEG + 1;
	localparam int MEM_DEPTH = SLOTS * HARMONICS;
	localparam int AW        = 17;
	localparam int FW        = 18;
	localparam int SW        = 24;

	// one unit of work handed from the front to the back
	typedef struct packed {
		logic                          rd;
		logic [PW-1:0]                 p1;
		logic [PW-1:0]                 p2;
		logic [HDEG:0][SW-1:0]         dre;
		logic [HDEG:0][SW-1:0]         dim;
	} job_t;

	// status the back reports to the front
	typedef struct packed {
		logic clearing;
	} back_stat_t;

endpackage

@@ src/bohacc_front.sv @@
module bohacc_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic                                op,
	input  logic [bohacc_pkg::PW-1:0]           first_particle,
	input  logic [bohacc_pkg::PW-1:0]           second_particle,
	input  logic signed [bohacc_pkg::FW-1:0]    bond_z,
	input  logic signed [bohacc_pkg::FW-1:0]    bond_sin,
	input  logic signed [bohacc_pkg::FW-1:0]    bond_cos,
	input  bohacc_pkg::back_stat_t              stat,
	output logic                                job_valid,
	input  logic                                job_ready,
	output bohacc_pkg::job_t                    job
);
	import bohacc_pkg::*;

	localparam int OW  = 34;
	localparam int PRW = 2 * OW;
	localparam int SQW = 58;
	localparam logic [5:0] LAST_PC = 6'd49;
	localparam logic signed [OW-1:0] N00 = 34'sd75724244;
	localparam logic signed [OW-1:0] ONE = 34'sd268435456;

	function automatic logic [63:0] isqrt_c(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		logic [63:0] w;
		r = '0;
		b = 64'h4000_0000_0000_0000;
		w = v;
		for (int i = 0; i < 32; i++) begin
			if (w >= r + b) begin
				w = w - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// recurrence coefficients, square roots of ratios in Q28
	localparam logic signed [OW-1:0] K3   = OW'(isqrt_c((64'd3 << 56) / 64'd1));
	localparam logic signed [OW-1:0] K5   = OW'(isqrt_c((64'd5 << 56) / 64'd1));
	localparam logic signed [OW-1:0] K7   = OW'(isqrt_c((64'd7 << 56) / 64'd1));
	localparam logic signed [OW-1:0] K9   = OW'(isqrt_c((64'd9 << 56) / 64'd1));
	localparam logic signed [OW-1:0] KD1  = OW'(isqrt_c((64'd3 << 56) / 64'd2));
	localparam logic signed [OW-1:0] KD2  = OW'(isqrt_c((64'd5 << 56) / 64'd4));
	localparam logic signed [OW-1:0] KD3  = OW'(isqrt_c((64'd7 << 56) / 64'd6));
	localparam logic signed [OW-1:0] KD4  = OW'(isqrt_c((64'd9 << 56) / 64'd8));
	localparam logic signed [OW-1:0] KA20 = OW'(isqrt_c((64'd15 << 56) / 64'd4));
	localparam logic signed [OW-1:0] KB20 = OW'(isqrt_c((64'd1 << 56) / 64'd3));
	localparam logic signed [OW-1:0] KA30 = OW'(isqrt_c((64'd35 << 56) / 64'd9));
	localparam logic signed [OW-1:0] KB30 = OW'(isqrt_c((64'd4 << 56) / 64'd15));
	localparam logic signed [OW-1:0] KA40 = OW'(isqrt_c((64'd63 << 56) / 64'd16));
	localparam logic signed [OW-1:0] KB40 = OW'(isqrt_c((64'd9 << 56) / 64'd35));
	localparam logic signed [OW-1:0] KA31 = OW'(isqrt_c((64'd35 << 56) / 64'd8));
	localparam logic signed [OW-1:0] KB31 = OW'(isqrt_c((64'd3 << 56) / 64'd15));
	localparam logic signed [OW-1:0] KA41 = OW'(isqrt_c((64'd63 << 56) / 64'd15));
	localparam logic signed [OW-1:0] KB41 = OW'(isqrt_c((64'd8 << 56) / 64'd35));
	localparam logic signed [OW-1:0] KA42 = OW'(isqrt_c((64'd63 << 56) / 64'd12));
	localparam logic signed [OW-1:0] KB42 = OW'(isqrt_c((64'd5 << 56) / 64'd35));

	typedef enum logic [2:0] {
		F_IDLE, F_PROD, F_SQRT, F_MUL, F_WB, F_ROUND, F_ENQ
	} fstate_t;

	typedef enum logic [5:0] {
		O_Z, O_CO2, O_S28, O_DG, O_A, O_B, O_T, O_CA, O_CB, O_SA, O_SB,
		O_Y0R, O_Y1R, O_Y2R, O_Y3R, O_Y4R, O_Y0I, O_Y1I, O_Y2I, O_Y3I, O_Y4I,
		O_K3, O_K5, O_K7, O_K9, O_KD1, O_KD2, O_KD3, O_KD4,
		O_KA20, O_KB20, O_KA30, O_KB30, O_KA40, O_KB40,
		O_KA31, O_KB31, O_KA41, O_KB41, O_KA42, O_KB42
	} opnd_t;

	// result = product, negated product, product minus old dst, old dst minus product
	typedef enum logic [1:0] {P_PLAIN, P_NEG, P_SUBR, P_RSUB} post_t;

	typedef struct packed {
		opnd_t x;
		opnd_t y;
		post_t post;
		opnd_t dst;
	} step_t;

	// microprogram: diagonal, column recurrence and azimuth terms, m = 0..4
	function automatic step_t prog(input logic [5:0] pc);
		case (pc)
			6'd0:  prog = '{O_Z,    O_DG,  P_PLAIN, O_T};
			6'd1:  prog = '{O_K3,   O_T,   P_PLAIN, O_B};
			6'd2:  prog = '{O_Z,    O_B,   P_PLAIN, O_T};
			6'd3:  prog = '{O_KB20, O_DG,  P_RSUB,  O_T};
			6'd4:  prog = '{O_KA20, O_T,   P_PLAIN, O_A};
			6'd5:  prog = '{O_Z,    O_A,   P_PLAIN, O_T};
			6'd6:  prog = '{O_KB30, O_B,   P_RSUB,  O_T};
			6'd7:  prog = '{O_KA30, O_T,   P_PLAIN, O_B};
			6'd8:  prog = '{O_Z,    O_B,   P_PLAIN, O_T};
			6'd9:  prog = '{O_KB40, O_A,   P_RSUB,  O_T};
			6'd10: prog = '{O_KA40, O_T,   P_PLAIN, O_A};
			6'd11: prog = '{O_A,    O_CA,  P_PLAIN, O_Y0R};
			6'd12: prog = '{O_A,    O_SA,  P_PLAIN, O_Y0I};
			6'd13: prog = '{O_S28,  O_DG,  P_PLAIN, O_T};
			6'd14: prog = '{O_KD1,  O_T,   P_NEG,   O_DG};
			6'd15: prog = '{O_Z,    O_DG,  P_PLAIN, O_T};
			6'd16: prog = '{O_K5,   O_T,   P_PLAIN, O_B};
			6'd17: prog = '{O_Z,    O_B,   P_PLAIN, O_T};
			6'd18: prog = '{O_KB31, O_DG,  P_RSUB,  O_T};
			6'd19: prog = '{O_KA31, O_T,   P_PLAIN, O_A};
			6'd20: prog = '{O_Z,    O_A,   P_PLAIN, O_T};
			6'd21: prog = '{O_KB41, O_B,   P_RSUB,  O_T};
			6'd22: prog = '{O_KA41, O_T,   P_PLAIN, O_B};
			6'd23: prog = '{O_B,    O_CB,  P_PLAIN, O_Y1R};
			6'd24: prog = '{O_B,    O_SB,  P_PLAIN, O_Y1I};
			6'd25: prog = '{O_S28,  O_DG,  P_PLAIN, O_T};
			6'd26: prog = '{O_KD2,  O_T,   P_NEG,   O_DG};
			6'd27: prog = '{O_CO2,  O_CB,  P_SUBR,  O_CA};
			6'd28: prog = '{O_CO2,  O_SB,  P_SUBR,  O_SA};
			6'd29: prog = '{O_Z,    O_DG,  P_PLAIN, O_T};
			6'd30: prog = '{O_K7,   O_T,   P_PLAIN, O_B};
			6'd31: prog = '{O_Z,    O_B,   P_PLAIN, O_T};
			6'd32: prog = '{O_KB42, O_DG,  P_RSUB,  O_T};
			6'd33: prog = '{O_KA42, O_T,   P_PLAIN, O_A};
			6'd34: prog = '{O_A,    O_CA,  P_PLAIN, O_Y2R};
			6'd35: prog = '{O_A,    O_SA,  P_PLAIN, O_Y2I};
			6'd36: prog = '{O_S28,  O_DG,  P_PLAIN, O_T};
			6'd37: prog = '{O_KD3,  O_T,   P_NEG,   O_DG};
			6'd38: prog = '{O_CO2,  O_CA,  P_SUBR,  O_CB};
			6'd39: prog = '{O_CO2,  O_SA,  P_SUBR,  O_SB};
			6'd40: prog = '{O_Z,    O_DG,  P_PLAIN, O_T};
			6'd41: prog = '{O_K9,   O_T,   P_PLAIN, O_B};
			6'd42: prog = '{O_B,    O_CB,  P_PLAIN, O_Y3R};
			6'd43: prog = '{O_B,    O_SB,  P_PLAIN, O_Y3I};
			6'd44: prog = '{O_S28,  O_DG,  P_PLAIN, O_T};
			6'd45: prog = '{O_KD4,  O_T,   P_NEG,   O_DG};
			6'd46: prog = '{O_CO2,  O_CB,  P_SUBR,  O_CA};
			6'd47: prog = '{O_CO2,  O_SB,  P_SUBR,  O_SA};
			6'd48: prog = '{O_DG,   O_CA,  P_PLAIN, O_Y4R};
			6'd49: prog = '{O_DG,   O_SA,  P_PLAIN, O_Y4I};
			default: prog = '{O_Z,  O_Z,   P_PLAIN, O_T};
		endcase
	endfunction

	function automatic logic signed [FW-1:0] clamp18(input logic signed [FW-1:0] v);
		if (v > 18'sd65536)
			return 18'sd65536;
		if (v < -18'sd65536)
			return -18'sd65536;
		return v;
	endfunction

	// round half away from zero, Q56 product back to Q28
	function automatic logic signed [OW-1:0] rnd28(input logic signed [PRW-1:0] v);
		logic [PRW-1:0]    m;
		logic [PRW-1:0]    u;
		logic signed [OW-1:0] r;
		m = v[PRW-1] ? PRW'(-v) : PRW'(v);
		u = (m + (PRW'(1) << 27)) >> 28;
		r = OW'(u);
		return v[PRW-1] ? -r : r;
	endfunction

	// round half away from zero, Q28 to Q16
	function automatic logic [SW-1:0] rnd12(input logic signed [OW-1:0] v);
		logic [OW-1:0] m;
		logic [OW-1:0] u;
		logic [SW-1:0] r;
		m = v[OW-1] ? OW'(-v) : OW'(v);
		u = (m + (OW'(1) << 11)) >> 12;
		r = SW'(u);
		return v[OW-1] ? SW'(-r) : r;
	endfunction

	fstate_t state_q;
	logic [5:0] pc_q;

	logic              rd_q;
	logic [PW-1:0]     p1_q;
	logic [PW-1:0]     p2_q;
	logic signed [FW-1:0] z_q;
	logic signed [OW-1:0] z28_q, co2_q, s28_q, dg_q, a_q, b_q, t_q;
	logic signed [OW-1:0] ca_q, cb_q, sa_q, sb_q;
	logic signed [OW-1:0] yr_q [HDEG+1];
	logic signed [OW-1:0] yi_q [HDEG+1];
	logic [SW-1:0]     dre_q [HDEG+1];
	logic [SW-1:0]     dim_q [HDEG+1];
	logic signed [PRW-1:0] prod_q;
	logic [SQW-1:0]    sv_q, sr_q, sb_bit_q;

	logic accept;
	logic signed [FW-1:0] zc, sc, cc;
	logic signed [FW:0]   zl, rad_lo, rad_hi;
	logic [2*FW-1:0]      rad;
	logic [SQW-1:0]       sq_sum, sq_r_next, sq_v_next;
	logic                 sq_ge;
	step_t                st;
	logic signed [OW-1:0] xval, yval, oldval, qv, res;

	function automatic logic signed [OW-1:0] opnd_val(input opnd_t o);
		case (o)
			O_Z:    return z28_q;
			O_CO2:  return co2_q;
			O_S28:  return s28_q;
			O_DG:   return dg_q;
			O_A:    return a_q;
			O_B:    return b_q;
			O_T:    return t_q;
			O_CA:   return ca_q;
			O_CB:   return cb_q;
			O_SA:   return sa_q;
			O_SB:   return sb_q;
			O_K3:   return K3;
			O_K5:   return K5;
			O_K7:   return K7;
			O_K9:   return K9;
			O_KD1:  return KD1;
			O_KD2:  return KD2;
			O_KD3:  return KD3;
			O_KD4:  return KD4;
			O_KA20: return KA20;
			O_KB20: return KB20;
			O_KA30: return KA30;
			O_KB30: return KB30;
			O_KA40: return KA40;
			O_KB40: return KB40;
			O_KA31: return KA31;
			O_KB31: return KB31;
			O_KA41: return KA41;
			O_KB41: return KB41;
			O_KA42: return KA42;
			O_KB42: return KB42;
			default: return '0;
		endcase
	endfunction

	assign full   = (state_q != F_IDLE) || stat.clearing;
	assign accept = push && !full;

	// clamp incoming bond fields
	assign zc = clamp18(bond_z);
	assign sc = clamp18(bond_sin);
	assign cc = clamp18(bond_cos);

	// (1 - z)(1 + z) in Q32
	assign zl     = {z_q[FW-1], z_q};
	assign rad_lo = 19'sd65536 - zl;
	assign rad_hi = 19'sd65536 + zl;
	assign rad    = rad_lo[FW-1:0] * rad_hi[FW-1:0];

	// one step of the bit-pair square root
	assign sq_sum    = sr_q + sb_bit_q;
	assign sq_ge     = sv_q >= sq_sum;
	assign sq_r_next = sq_ge ? (sr_q >> 1) + sb_bit_q : sr_q >> 1;
	assign sq_v_next = sq_ge ? sv_q - sq_sum : sv_q;

	// operand fetch and write-back value
	always_comb begin
		st     = prog(pc_q);
		xval   = opnd_val(st.x);
		yval   = opnd_val(st.y);
		oldval = opnd_val(st.dst);
		qv     = rnd28(prod_q);
		case (st.post)
			P_PLAIN: res = qv;
			P_NEG:   res = -qv;
			P_SUBR:  res = qv - oldval;
			P_RSUB:  res = oldval - qv;
			default: res = qv;
		endcase
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			pc_q    <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept)
						state_q <= op ? F_ENQ : F_PROD;
				end
				F_PROD: state_q <= F_SQRT;
				F_SQRT: begin
					if (sb_bit_q[0]) begin
						pc_q    <= '0;
						state_q <= F_MUL;
					end
				end
				F_MUL: state_q <= F_WB;
				F_WB: begin
					if (pc_q == LAST_PC) begin
						state_q <= F_ROUND;
					end else begin
						pc_q    <= pc_q + 6'd1;
						state_q <= F_MUL;
					end
				end
				F_ROUND: state_q <= F_ENQ;
				F_ENQ: begin
					if (job_ready)
						state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (accept) begin
					rd_q  <= op;
					p1_q  <= first_particle;
					p2_q  <= second_particle;
					z_q   <= zc;
					z28_q <= {{(OW-FW){zc[FW-1]}}, zc} <<< 12;
					co2_q <= {{(OW-FW){cc[FW-1]}}, cc} <<< 13;
					ca_q  <= ONE;
					cb_q  <= {{(OW-FW){cc[FW-1]}}, cc} <<< 12;
					sa_q  <= '0;
					sb_q  <= {{(OW-FW){sc[FW-1]}}, sc} <<< 12;
					dg_q  <= N00;
				end
			end
			F_PROD: begin
				sv_q     <= SQW'(rad) << 24;
				sr_q     <= '0;
				sb_bit_q <= SQW'(1) << 56;
			end
			F_SQRT: begin
				sv_q     <= sq_v_next;
				sr_q     <= sq_r_next;
				sb_bit_q <= sb_bit_q >> 2;
				if (sb_bit_q[0])
					s28_q <= OW'(sq_r_next);
			end
			F_MUL: prod_q <= xval * yval;
			F_WB: begin
				case (st.dst)
					O_DG:  dg_q     <= res;
					O_A:   a_q      <= res;
					O_B:   b_q      <= res;
					O_T:   t_q      <= res;
					O_CA:  ca_q     <= res;
					O_CB:  cb_q     <= res;
					O_SA:  sa_q     <= res;
					O_SB:  sb_q     <= res;
					O_Y0R: yr_q[0]  <= res;
					O_Y1R: yr_q[1]  <= res;
					O_Y2R: yr_q[2]  <= res;
					O_Y3R: yr_q[3]  <= res;
					O_Y4R: yr_q[4]  <= res;
					O_Y0I: yi_q[0]  <= res;
					O_Y1I: yi_q[1]  <= res;
					O_Y2I: yi_q[2]  <= res;
					O_Y3I: yi_q[3]  <= res;
					O_Y4I: yi_q[4]  <= res;
					default: t_q    <= t_q;
				endcase
			end
			F_ROUND: begin
				for (int k = 0; k <= HDEG; k++) begin
					dre_q[k] <= rnd12(yr_q[k]);
					dim_q[k] <= rnd12(yi_q[k]);
				end
			end
			default: begin
			end
		endcase
	end

	// hand the finished job to the queue
	assign job_valid = (state_q == F_ENQ);
	always_comb begin
		job.rd = rd_q;
		job.p1 = p1_q;
		job.p2 = p2_q;
		for (int k = 0; k <= HDEG; k++) begin
			job.dre[k] = dre_q[k];
			job.dim[k] = dim_q[k];
		end
	end

endmodule

@@ src/bohacc_queue.sv @@
module bohacc_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  bohacc_pkg::job_t  in_job,
	output logic              out_valid,
	input  logic              out_ready,
	output bohacc_pkg::job_t  out_job
);
	import bohacc_pkg::*;

	job_t       ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_job   = ent_q[rp_q];
	assign wr        = in_valid && in_ready;
	assign rd        = out_valid && out_ready;

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr)
				wp_q <= ~wp_q;
			if (rd)
				rp_q <= ~rp_q;
			case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// hold entries
	always_ff @(posedge clk) begin
		if (wr)
			ent_q[wp_q] <= in_job;
	end

endmodule

@@ src/bohacc_back.sv @@
module bohacc_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              job_valid,
	output logic                              job_ready,
	input  bohacc_pkg::job_t                  job,
	output bohacc_pkg::back_stat_t            stat,
	output logic                              empty,
	input  logic                              pop,
	output logic [bohacc_pkg::PW-1:0]         particle,
	output logic signed [3:0]                 order_m,
	output logic signed [bohacc_pkg::SW-1:0]  real_part,
	output logic signed [bohacc_pkg::SW-1:0]  imag_part,
	output logic                              last
);
	import bohacc_pkg::*;

	localparam int ADD_SLOTS = 2 * HARMONICS;

	typedef enum logic [2:0] {B_CLEAR, B_IDLE, B_ADD, B_RISSUE, B_RCAP} bstate_t;

	bstate_t        state_q;
	logic [AW-1:0]  clr_q;
	logic [4:0]     cnt_q;
	job_t           jb_q;
	logic           wv_s1;
	logic [AW-1:0]  wa_s1;
	logic [3:0]     wj_s1;
	logic           out_v_q;
	logic [2*SW-1:0] mem [MEM_DEPTH];
	logic [2*SW-1:0] rdata_q;

	logic           issue;
	logic [PW-1:0]  rp;
	logic [3:0]     rj;
	logic [AW-1:0]  rd_addr;
	logic           we;
	logic [AW-1:0]  wa;
	logic [2*SW-1:0] wd;
	logic [2:0]     k;
	logic           neg_side;
	logic signed [SW-1:0] dre, dim, dr, di;

	function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] a, input logic [SW-1:0] d);
		logic signed [SW:0] t;
		t = $signed({a[SW-1], a}) + $signed({d[SW-1], d});
		if (t > $signed({2'b00, {(SW-1){1'b1}}}))
			return {1'b0, {(SW-1){1'b1}}};
		if (t < $signed({2'b11, {(SW-1){1'b0}}}))
			return {1'b1, {(SW-1){1'b0}}};
		return t[SW-1:0];
	endfunction

	assign stat.clearing = (state_q == B_CLEAR);
	assign job_ready     = (state_q == B_IDLE);
	assign empty         = !out_v_q;
	assign issue         = (state_q == B_ADD) && (cnt_q < 5'(ADD_SLOTS));

	// read address: slot = particle * 9 + m index
	always_comb begin
		if (state_q == B_ADD) begin
			rp = (cnt_q < 5'(HARMONICS)) ? jb_q.p1 : jb_q.p2;
			rj = (cnt_q < 5'(HARMONICS)) ? cnt_q[3:0] : 4'(cnt_q - 5'(HARMONICS));
		end else begin
			rp = jb_q.p1;
			rj = cnt_q[3:0];
		end
		rd_addr = AW'({rp, 3'b000}) + AW'(rp) + AW'(rj);
	end

	// delta for the slot in flight: negative m conjugates, odd negative m flips sign
	always_comb begin
		neg_side = (wj_s1 < 4'(HDEG));
		k        = neg_side ? 3'(4'(HDEG) - wj_s1) : 3'(wj_s1 - 4'(HDEG));
		dre      = $signed(jb_q.dre[k]);
		dim      = $signed(jb_q.dim[k]);
		dr       = (neg_side && k[0])  ? -dre : dre;
		di       = (neg_side && !k[0]) ? -dim : dim;
	end

	assign we = (state_q == B_CLEAR) || wv_s1;
	assign wa = (state_q == B_CLEAR) ? clr_q : wa_s1;
	assign wd = (state_q == B_CLEAR) ? '0 :
		{sat_add(rdata_q[2*SW-1:SW], dr), sat_add(rdata_q[SW-1:0], di)};

	// control: clearing pass, add sweep, read-out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLEAR;
			clr_q   <= '0;
			cnt_q   <= '0;
			wv_s1   <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			wv_s1 <= issue;
			if (pop && out_v_q)
				out_v_q <= 1'b0;
			case (state_q)
				B_CLEAR: begin
					if (clr_q == AW'(MEM_DEPTH - 1))
						state_q <= B_IDLE;
					else
						clr_q <= clr_q + AW'(1);
				end
				B_IDLE: begin
					if (job_valid) begin
						cnt_q   <= '0;
						state_q <= job.rd ? B_RISSUE : B_ADD;
					end
				end
				B_ADD: begin
					if (issue)
						cnt_q <= cnt_q + 5'd1;
					else
						state_q <= B_IDLE;
				end
				B_RISSUE: begin
					if (!out_v_q)
						state_q <= B_RCAP;
				end
				B_RCAP: begin
					out_v_q <= 1'b1;
					if (cnt_q == 5'(HARMONICS - 1)) begin
						state_q <= B_IDLE;
					end else begin
						cnt_q   <= cnt_q + 5'd1;
						state_q <= B_RISSUE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// payload: job copy, write pipeline, memory, result register
	always_ff @(posedge clk) begin
		if ((state_q == B_IDLE) && job_valid)
			jb_q <= job;
		wa_s1   <= rd_addr;
		wj_s1   <= rj;
		rdata_q <= mem[rd_addr];
		if (we)
			mem[wa] <= wd;
		if (state_q == B_RCAP) begin
			particle  <= jb_q.p1;
			order_m   <= $signed(cnt_q[3:0] - 4'(HDEG));
			real_part <= $signed(rdata_q[2*SW-1:SW]);
			imag_part <= $signed(rdata_q[SW-1:0]);
			last      <= (cnt_q == 5'(HARMONICS - 1));
		end
	end

endmodule

@@ src/bond_order_harmonic_accumulator.sv @@
// Degree-four bond-order accumulator. Each add beat carries one bond (two
// particles, clamped z, azimuth sine and cosine) and adds the nine harmonics
// Y_4m, m = -4..4, into saturating Q7.16 complex sums of both particles; a
// read beat returns one particle's nine sums, m ascending, last on m = 4.
// An add passes through the front in order: a 29-step bit-pair square
// root for sqrt(1 - z^2), then 50 microcoded products on one shared 34x34
// multiplier, then rounding and hand-off. The back then does one memory
// read-modify-write per slot for an add, and presents each read result
// only after the previous one has been popped. A two-entry job queue lets
// the front work on the next bond while the back updates memory. After
// reset a clearing pass zeroes the 73728 sums; full stays high until it ends.
module bond_order_harmonic_accumulator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic                              op,
	input  logic [bohacc_pkg::PW-1:0]         first_particle,
	input  logic [bohacc_pkg::PW-1:0]         second_particle,
	input  logic signed [bohacc_pkg::FW-1:0]  bond_z,
	input  logic signed [bohacc_pkg::FW-1:0]  bond_sin,
	input  logic signed [bohacc_pkg::FW-1:0]  bond_cos,
	output logic                              empty,
	input  logic                              pop,
	output logic [bohacc_pkg::PW-1:0]         particle,
	output logic signed [3:0]                 order_m,
	output logic signed [bohacc_pkg::SW-1:0]  real_part,
	output logic signed [bohacc_pkg::SW-1:0]  imag_part,
	output logic                              last
);
	import bohacc_pkg::*;

	back_stat_t stat;
	logic       f_valid, f_ready, b_valid, b_ready;
	job_t       f_job, b_job;

	// compute harmonics per bond
	bohacc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.op              (op),
		.first_particle  (first_particle),
		.second_particle (second_particle),
		.bond_z          (bond_z),
		.bond_sin        (bond_sin),
		.bond_cos        (bond_cos),
		.stat            (stat),
		.job_valid       (f_valid),
		.job_ready       (f_ready),
		.job             (f_job)
	);

	// decouple front and back
	bohacc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_job    (f_job),
		.out_valid (b_valid),
		.out_ready (b_ready),
		.out_job   (b_job)
	);

	// accumulate and read out
	bohacc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (b_valid),
		.job_ready (b_ready),
		.job       (b_job),
		.stat      (stat),
		.empty     (empty),
		.pop       (pop),
		.particle  (particle),
		.order_m   (order_m),
		.real_part (real_part),
		.imag_part (imag_part),
		.last      (last)
	);

endmodule
